### sv/slfd_pkg.sv
// Shared types and constants for the sync/length frame deframer.
// No dependencies; imported by every module of the block.
package slfd_pkg;

    localparam logic [7:0]  SYNC_FIRST      = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND     = 8'h5A;
    localparam logic [15:0] DEFAULT_MAX_LEN = 16'd256;

    // One result word: a payload byte with its frame markers.
    typedef struct packed {
        logic [15:0] frame_length;
        logic        last_of_frame;
        logic        first_of_frame;
        logic [7:0]  payload_byte;
    } t_result;

endpackage

### sv/slfd_in_stage.sv
// Input register of the deframer: holds one received byte until the core takes it.
// Depends on slfd_pkg.
module slfd_in_stage import slfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    output logic       o_valid,
    output logic [7:0] o_data,
    input  logic       i_take
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

endmodule

### sv/slfd_core.sv
// Frame state machine: sync hunt, length header check and payload marking.
// Depends on slfd_pkg.
module slfd_core import slfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_max_len,
    input  logic        i_out_ready,
    output logic        o_take,
    output logic        o_res_valid,
    output t_result     o_res
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SAW_A5  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [15:0] hdr_len;
    logic [15:0] count_inc;
    logic        last;

    assign o_take    = i_valid && i_out_ready;
    assign hdr_len   = {i_byte, r_len_lo};
    assign count_inc = r_count + 16'd1;
    assign last      = (count_inc >= r_len);

    assign o_res_valid          = o_take && (r_phase == PH_PAYLOAD);
    assign o_res.payload_byte   = i_byte;
    assign o_res.first_of_frame = (r_count == 16'd0);
    assign o_res.last_of_frame  = last;
    assign o_res.frame_length   = r_len;

    always_comb begin
        n_phase  = r_phase;
        n_len_lo = r_len_lo;
        n_len    = r_len;
        n_count  = r_count;
        case (r_phase)
            PH_SAW_A5: begin
                if (i_byte == SYNC_SECOND) begin
                    n_phase = PH_LEN_LO;
                end else if (i_byte != SYNC_FIRST) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_LEN_LO: begin
                n_len_lo = i_byte;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                if (hdr_len == 16'd0 || hdr_len > i_max_len) begin
                    // rescan the rejected length bytes for a sync pair
                    if (r_len_lo == SYNC_FIRST && i_byte == SYNC_SECOND) begin
                        n_phase = PH_LEN_LO;
                    end else if (i_byte == SYNC_FIRST) begin
                        n_phase = PH_SAW_A5;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end else begin
                    n_len   = hdr_len;
                    n_count = 16'd0;
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_count = count_inc;
                if (last) begin
                    n_phase = PH_HUNT;
                    n_count = 16'd0;
                end
            end
            default: begin
                n_phase = (i_byte == SYNC_FIRST) ? PH_SAW_A5 : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_len_lo <= 8'd0;
            r_len    <= 16'd0;
            r_count  <= 16'd0;
        end else if (o_take) begin
            r_phase  <= n_phase;
            r_len_lo <= n_len_lo;
            r_len    <= n_len;
            r_count  <= n_count;
        end
    end

endmodule

### sv/slfd_out_stage.sv
// Result register of the deframer: holds one payload word for the master side.
// Depends on slfd_pkg.
module slfd_out_stage import slfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_result     i_res,
    output logic        o_ready,
    output logic        o_valid,
    output t_result     o_res,
    input  logic        i_ready
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

### sv/sync_length_frame_deframer_top.sv
// Sync-word, length-prefixed frame deframer: top level.
// A payload byte passes the input register, then the combinational state machine, then the result register.
// Throughput: one byte per cycle while the result register can take a word; the core stalls otherwise.
// Reset (i_rst_n low, synchronous): hunt for sync, empty both registers, max length 256.
// Depends on slfd_pkg, slfd_in_stage, slfd_core and slfd_out_stage.
module sync_length_frame_deframer_top import slfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // max_payload_len
    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // payload words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] frame_length
    output logic        m_axis_tlast,   // last_of_frame
    output logic        m_axis_tuser    // first_of_frame
);

    logic [15:0] r_max_len;
    logic        in_valid;
    logic [7:0]  in_byte;
    logic        take;
    logic        out_ready;
    logic        res_valid;
    t_result     res;
    t_result     out_res;

    // Configuration is always taken; the user must write it only while the block is idle (not enforced here).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= DEFAULT_MAX_LEN;
        end else if (i_cfg_valid) begin
            r_max_len <= i_cfg_data;
        end
    end

    // Hold each received word until the state machine can advance on it.
    slfd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (in_valid),
        .o_data  (in_byte),
        .i_take  (take)
    );

    // Advance the frame state one byte at a time; emit a word for payload bytes only.
    // The core stalls whenever the result register cannot take a new word.
    slfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .i_max_len   (r_max_len),
        .i_out_ready (out_ready),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register parts the master side from the core.
    slfd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out_res.frame_length, out_res.payload_byte};
    assign m_axis_tlast = out_res.last_of_frame;
    assign m_axis_tuser = out_res.first_of_frame;

endmodule
